// File: hdl/psrc_pkg.sv
// ----------------------------------------------------------------------------
// PGM sample rescale codec package
// Shared widths, constants and register codes for the rescale codec and its
// channel interfaces.
// ----------------------------------------------------------------------------
package psrc_pkg;

    // Field widths.
    localparam int DATA_W = 16;
    localparam int BYTE_W = 8;

    // One shift-add or one restoring-division step per cycle.
    localparam int STEPS = DATA_W;
    localparam int CNT_W = $clog2(STEPS);

    // Full-scale pixel value and the threshold for two-byte samples.
    localparam logic [DATA_W-1:0] FULL_SCALE      = 16'hFFFF;
    localparam logic [DATA_W-1:0] WIDE_LIMIT      = 16'd256;
    localparam logic [DATA_W-1:0] MAX_VALUE_RESET = 16'd255;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_DIRECTION = 1'b0,
        REG_MAX_VALUE = 1'b1
    } t_reg_index;

    // Conversion direction.
    typedef enum logic [0:0] {
        DIR_DECODE = 1'b0,
        DIR_ENCODE = 1'b1
    } t_direction;

endpackage

// File: hdl/psrc_if.sv
// ----------------------------------------------------------------------------
// PGM sample rescale codec channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------

// Input item channel.
interface psrc_in_if;
    logic                        valid;
    logic                        ready;
    logic [psrc_pkg::DATA_W-1:0] data_in;
    logic                        last_in;

    modport source (output valid, output data_in, output last_in, input ready);
    modport sink   (input valid, input data_in, input last_in, output ready);
endinterface

// Result item channel.
interface psrc_out_if;
    logic                        valid;
    logic                        ready;
    logic [psrc_pkg::DATA_W-1:0] data_out;
    logic                        run_last;
    logic                        buffer_end;
    logic                        clipped;

    modport source (output valid, output data_out, output run_last,
                    output buffer_end, output clipped, input ready);
    modport sink   (input valid, input data_out, input run_last,
                    input buffer_end, input clipped, output ready);
endinterface

// Configuration write channel.
interface psrc_cfg_if;
    logic                        valid;
    logic                        ready;
    psrc_pkg::t_reg_index        index;
    logic [psrc_pkg::DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/pgm_sample_rescale_codec.sv
// ----------------------------------------------------------------------------
// PGM sample rescale codec
// Converts raw PGM sample bytes to 16-bit full-scale pixels and back.
// ----------------------------------------------------------------------------
// An item that produces a result moves from ST_IDLE through ST_MUL or ST_DIV
// to ST_FIN, where its result is loaded into the output register, and the
// next input transaction can be taken in the cycle after that. Decode spends
// ST_DIV in a restoring divider that produces one quotient bit per cycle of
// sample*65535/max_value. Encode spends ST_MUL in a shift-add multiplier that
// consumes one pixel bit per cycle of pixel*max_value; the ST_FIN step that
// loads the result also folds the 32-bit product into a division by 65535. A
// sample above max_value skips the divider and goes from ST_IDLE straight to
// ST_FIN, and the first byte of a two-byte sample is only held in ST_IDLE.
// One item is worked on at a time; the next input transaction is
// taken as soon as the previous result has moved into the output register,
// so a waiting result does not stall the input. A finished item waits in
// ST_FIN while the output register is still full. The two bytes of a
// wide encode leave on consecutive output transactions.
// ----------------------------------------------------------------------------
module pgm_sample_rescale_codec (
    input  logic             i_clk,
    input  logic             i_rst_n,
    psrc_in_if.sink          i_in,
    psrc_out_if.source       o_out,
    psrc_cfg_if.sink         i_cfg
);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    localparam int DW = psrc_pkg::DATA_W;
    localparam int BW = psrc_pkg::BYTE_W;
    localparam logic [psrc_pkg::CNT_W-1:0] LAST_STEP = psrc_pkg::CNT_W'(psrc_pkg::STEPS - 1);
    localparam logic [DW:0] FOLD_ONE = {1'b0, psrc_pkg::FULL_SCALE};
    localparam logic [DW:0] FOLD_TWO = {psrc_pkg::FULL_SCALE, 1'b0};

    // Configuration registers.
    psrc_pkg::t_direction r_direction, n_direction;
    logic [DW-1:0]        r_max_value, n_max_value;

    // Byte pairing state.
    logic                 r_pair_phase, n_pair_phase;
    logic [BW-1:0]        r_held, n_held;

    // Sequencer and arithmetic datapath.
    t_state               r_state, n_state;
    logic [psrc_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [DW-1:0]        r_acc_hi, n_acc_hi;
    logic [DW-1:0]        r_acc_lo, n_acc_lo;
    logic [DW-1:0]        r_mul, n_mul;
    logic                 r_item_enc, n_item_enc;
    logic                 r_item_wide, n_item_wide;
    logic                 r_item_last, n_item_last;
    logic                 r_item_clip, n_item_clip;

    // Output register and the pending low byte of a wide encode.
    logic                 r_out_valid, n_out_valid;
    logic [DW-1:0]        r_out_data, n_out_data;
    logic                 r_out_run_last, n_out_run_last;
    logic                 r_out_buf_end, n_out_buf_end;
    logic                 r_out_clip, n_out_clip;
    logic                 r_pend, n_pend;
    logic [BW-1:0]        r_pend_data, n_pend_data;
    logic                 r_pend_buf_end, n_pend_buf_end;

    // Decoded handshakes and datapath terms.
    logic                 in_fire, out_fire, cfg_fire, can_load;
    logic                 wide;
    logic [BW-1:0]        byte_in;
    logic [DW-1:0]        sample;
    logic [2*DW-1:0]      dividend;
    logic [DW:0]          div_trial, div_rem;
    logic                 div_ge;
    logic [DW:0]          mul_sum;
    logic [DW:0]          fold;
    logic [DW-1:0]        fold_corr;
    logic [DW-1:0]        enc_q;
    logic [DW-1:0]        fin_data;

    // Handshakes.
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && (r_state == ST_IDLE);
    assign out_fire    = r_out_valid && o_out.ready;
    assign cfg_fire    = i_cfg.valid;
    assign can_load    = !r_out_valid || (o_out.ready && !r_pend);

    // Output channel drive.
    assign o_out.valid      = r_out_valid;
    assign o_out.data_out   = r_out_data;
    assign o_out.run_last   = r_out_run_last;
    assign o_out.buffer_end = r_out_buf_end;
    assign o_out.clipped    = r_out_clip;

    // Sample assembly and the decode dividend sample*65535 = (sample << 16) - sample.
    assign wide     = (r_max_value >= psrc_pkg::WIDE_LIMIT);
    assign byte_in  = i_in.data_in[BW-1:0];
    assign sample   = wide ? {r_held, byte_in} : {{(DW-BW){1'b0}}, byte_in};
    assign dividend = {sample, {DW{1'b0}}} - {{DW{1'b0}}, sample};

    // One restoring division step: the quotient bit shifts into the low half.
    assign div_trial = {r_acc_hi, r_acc_lo[DW-1]};
    assign div_ge    = (div_trial >= {1'b0, r_max_value});
    assign div_rem   = div_trial - {1'b0, r_max_value};

    // One shift-add multiplication step on the low multiplier bit.
    assign mul_sum = {1'b0, r_acc_hi} + (r_mul[0] ? {1'b0, r_max_value} : {(DW+1){1'b0}});

    // Division of the product by 65535: q = hi + (hi + lo) / 65535, where the
    // folded sum is below three times the divisor.
    assign fold = {1'b0, r_acc_hi} + {1'b0, r_acc_lo};
    always_comb begin
        if (fold >= FOLD_TWO) begin
            fold_corr = DW'(2);
        end else if (fold >= FOLD_ONE) begin
            fold_corr = DW'(1);
        end else begin
            fold_corr = '0;
        end
    end
    assign enc_q    = r_acc_hi + fold_corr;
    assign fin_data = r_item_enc ? enc_q : r_acc_lo;

    // Next-state logic.
    always_comb begin
        n_direction    = r_direction;
        n_max_value    = r_max_value;
        n_pair_phase   = r_pair_phase;
        n_held         = r_held;
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_acc_hi       = r_acc_hi;
        n_acc_lo       = r_acc_lo;
        n_mul          = r_mul;
        n_item_enc     = r_item_enc;
        n_item_wide    = r_item_wide;
        n_item_last    = r_item_last;
        n_item_clip    = r_item_clip;
        n_out_valid    = r_out_valid;
        n_out_data     = r_out_data;
        n_out_run_last = r_out_run_last;
        n_out_buf_end  = r_out_buf_end;
        n_out_clip     = r_out_clip;
        n_pend         = r_pend;
        n_pend_data    = r_pend_data;
        n_pend_buf_end = r_pend_buf_end;

        // Register writes; a zero max value is ignored.
        if (cfg_fire) begin
            case (i_cfg.index)
                psrc_pkg::REG_DIRECTION: begin
                    n_direction = psrc_pkg::t_direction'(i_cfg.data[0]);
                end
                psrc_pkg::REG_MAX_VALUE: begin
                    if (i_cfg.data != '0) begin
                        n_max_value = i_cfg.data;
                    end
                end
                default: begin
                end
            endcase
        end

        // The output register drains, then refills from the pending low byte.
        if (out_fire) begin
            if (r_pend) begin
                n_out_data     = {{(DW-BW){1'b0}}, r_pend_data};
                n_out_run_last = 1'b1;
                n_out_buf_end  = r_pend_buf_end;
                n_out_clip     = 1'b0;
                n_pend         = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end

        // Sequencer.
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_item_last  = i_in.last_in;
                    n_item_wide  = wide;
                    n_item_clip  = 1'b0;
                    n_cnt        = '0;
                    n_pair_phase = 1'b0;
                    if (r_direction == psrc_pkg::DIR_ENCODE) begin
                        n_item_enc = 1'b1;
                        n_acc_hi   = '0;
                        n_mul      = i_in.data_in;
                        n_state    = ST_MUL;
                    end else if (wide && !r_pair_phase) begin
                        // High byte of a pair: hold it and wait for the low byte.
                        n_held       = byte_in;
                        n_pair_phase = !i_in.last_in;
                    end else if (sample > r_max_value) begin
                        n_item_enc  = 1'b0;
                        n_item_clip = 1'b1;
                        n_acc_lo    = psrc_pkg::FULL_SCALE;
                        n_state     = ST_FIN;
                    end else begin
                        n_item_enc = 1'b0;
                        n_acc_hi   = dividend[2*DW-1:DW];
                        n_acc_lo   = dividend[DW-1:0];
                        n_state    = ST_DIV;
                    end
                end
            end
            ST_MUL: begin
                n_acc_hi = mul_sum[DW:1];
                n_acc_lo = {mul_sum[0], r_acc_lo[DW-1:1]};
                n_mul    = {1'b0, r_mul[DW-1:1]};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                n_acc_hi = div_ge ? div_rem[DW-1:0] : div_trial[DW-1:0];
                n_acc_lo = {r_acc_lo[DW-2:0], div_ge};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_clip  = r_item_clip;
                    if (r_item_enc && r_item_wide) begin
                        // High byte first, low byte held for the next transaction.
                        n_out_data     = {{(DW-BW){1'b0}}, fin_data[DW-1:BW]};
                        n_out_run_last = 1'b0;
                        n_out_buf_end  = 1'b0;
                        n_pend         = 1'b1;
                        n_pend_data    = fin_data[BW-1:0];
                        n_pend_buf_end = r_item_last;
                    end else if (r_item_enc) begin
                        n_out_data     = {{(DW-BW){1'b0}}, fin_data[BW-1:0]};
                        n_out_run_last = 1'b1;
                        n_out_buf_end  = r_item_last;
                    end else begin
                        n_out_data     = fin_data;
                        n_out_run_last = 1'b1;
                        n_out_buf_end  = r_item_last;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= psrc_pkg::DIR_DECODE;
            r_max_value  <= psrc_pkg::MAX_VALUE_RESET;
            r_pair_phase <= 1'b0;
            r_held       <= '0;
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_direction  <= n_direction;
            r_max_value  <= n_max_value;
            r_pair_phase <= n_pair_phase;
            r_held       <= n_held;
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_pend       <= n_pend;
        end
    end

    // Datapath and payload registers.
    always_ff @(posedge i_clk) begin
        r_cnt          <= n_cnt;
        r_acc_hi       <= n_acc_hi;
        r_acc_lo       <= n_acc_lo;
        r_mul          <= n_mul;
        r_item_enc     <= n_item_enc;
        r_item_wide    <= n_item_wide;
        r_item_last    <= n_item_last;
        r_item_clip    <= n_item_clip;
        r_out_data     <= n_out_data;
        r_out_run_last <= n_out_run_last;
        r_out_buf_end  <= n_out_buf_end;
        r_out_clip     <= n_out_clip;
        r_pend_data    <= n_pend_data;
        r_pend_buf_end <= n_pend_buf_end;
    end

endmodule

// File: hdl/psrc_checker.sv
// ----------------------------------------------------------------------------
// PGM sample rescale codec checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module psrc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [psrc_pkg::DATA_W-1:0] i_out_data,
    input logic                        i_out_run_last,
    input logic                        i_out_buffer_end,
    input logic                        i_out_clipped
);

    // A result that has not been taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transaction");

    // The low byte of a two-byte sample is offered right after the high byte.
    a_second_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_run_last |=> i_out_valid && i_out_run_last)
        else $error("second byte of a sample did not follow");

    // A buffer can only end on the last result of an item.
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_buffer_end |-> i_out_run_last)
        else $error("buffer end on a result that is not the last of its item");

    // A clipped sample is saturated to full scale.
    a_clip_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_clipped |-> i_out_data == psrc_pkg::FULL_SCALE)
        else $error("clipped result is not full scale");

endmodule

bind pgm_sample_rescale_codec psrc_checker u_psrc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_data       (o_out.data_out),
    .i_out_run_last   (o_out.run_last),
    .i_out_buffer_end (o_out.buffer_end),
    .i_out_clipped    (o_out.clipped)
);
